@@ rtl/core/mau_pkg.sv @@
`default_nettype none
package mau_pkg;

  localparam int AccW    = 16;
  localparam int GyroW   = 32;
  localparam int DtW     = 24;
  localparam int GainW   = 24;
  localparam int QuatW   = 32;
  localparam int CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] RegPropGain  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegIntegGain = 1'd1;

  localparam logic [GainW-1:0] PropGainRst  = 24'd52429;
  localparam logic [GainW-1:0] IntegGainRst = 24'd0;

  localparam int MulW  = 35;
  localparam int ProdW = 70;
  localparam int AccuW = 72;
  localparam int RateW = 40;
  localparam int TW    = 40;
  localparam int HeW   = 35;
  localparam int HvW   = 34;
  localparam int AnW   = 33;
  localparam int HincW = 34;
  localparam int CW    = 36;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_MAC    = 10'b00_0000_0010,
    S_POST   = 10'b00_0000_0100,
    S_SQRT   = 10'b00_0000_1000,
    S_SQDONE = 10'b00_0001_0000,
    S_DINIT  = 10'b00_0010_0000,
    S_DIV    = 10'b00_0100_0000,
    S_DPOST  = 10'b00_1000_0000,
    S_NORM   = 10'b01_0000_0000,
    S_OUT    = 10'b10_0000_0000
  } state_e;

  typedef enum logic [4:0] {
    J_SS, J_HV0, J_HV1, J_HV2, J_HE0, J_HE1, J_HE2,
    J_T, J_I, J_P, J_H, J_C0, J_C1, J_C2, J_C3, J_VV
  } job_e;

endpackage
`default_nettype wire

@@ rtl/core/mau_ifs.sv @@
`default_nettype none
interface mau_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [mau_pkg::AccW-1:0]  accel_x;
  logic signed [mau_pkg::AccW-1:0]  accel_y;
  logic signed [mau_pkg::AccW-1:0]  accel_z;
  logic signed [mau_pkg::GyroW-1:0] gyro_x;
  logic signed [mau_pkg::GyroW-1:0] gyro_y;
  logic signed [mau_pkg::GyroW-1:0] gyro_z;
  logic        [mau_pkg::DtW-1:0]   time_step;
  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  time_step, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                time_step, output ready);
endinterface

interface mau_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [mau_pkg::QuatW-1:0] quat_w;
  logic signed [mau_pkg::QuatW-1:0] quat_x;
  logic signed [mau_pkg::QuatW-1:0] quat_y;
  logic signed [mau_pkg::QuatW-1:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface mau_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mau_pkg::CfgIdxW-1:0]        index;
  logic [mau_pkg::GainW-1:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/mahony_attitude_update_top.sv @@
// When an accelerometer axis is zero, the accelerometer correction is skipped and only
// the gyro rates are integrated. One word is in work at a time: a new input word is
// accepted only in the idle state, once the result of the last one is in the output register.
// The work runs through the 32-step square-root and divider loops and through the one
// shared multiplier. Reset restores the gains, the identity attitude and a zero integral.
`default_nettype none
module mahony_attitude_update_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  mau_in_if.sink    sample_i,
  mau_out_if.source result_o,
  mau_cfg_if.sink   cfg_i
);

  localparam int MulW  = mau_pkg::MulW;
  localparam int ProdW = mau_pkg::ProdW;
  localparam int AccuW = mau_pkg::AccuW;
  localparam int RateW = mau_pkg::RateW;
  localparam int TW    = mau_pkg::TW;
  localparam int HeW   = mau_pkg::HeW;
  localparam int HvW   = mau_pkg::HvW;
  localparam int AnW   = mau_pkg::AnW;
  localparam int HincW = mau_pkg::HincW;
  localparam int CW    = mau_pkg::CW;
  localparam int QuatW = mau_pkg::QuatW;

  localparam logic signed [AccuW-1:0] HalfQ60 = 72'sd576460752303423488;
  localparam logic signed [AccuW-1:0] IncLim  = 72'sd2147483648;
  localparam logic signed [AnW-1:0]   OneQ30s = 33'sd1073741824;
  localparam logic signed [QuatW-1:0] OneQ30  = 32'sd1073741824;

  mau_pkg::state_e state_q, state_d;
  mau_pkg::job_e   job_q, job_d;
  logic [2:0] tm_q, tm_d;
  logic [1:0] ax_q, ax_d;
  logic [1:0] dk_q, dk_d;
  logic [4:0] cnt_q, cnt_d;
  logic [mau_pkg::GainW-1:0] prop_q, prop_d, igain_q, igain_d;
  logic signed [QuatW-1:0] quat_q [4], quat_d [4];
  logic signed [31:0]      integ_q [3], integ_d [3];
  logic out_valid_q, out_valid_d;

  logic signed [mau_pkg::AccW-1:0] a_q [3], a_d [3];
  logic [mau_pkg::DtW-1:0] dt_q, dt_d;
  logic signed [AnW-1:0]   an_q [3], an_d [3];
  logic signed [HvW-1:0]   hv_q [3], hv_d [3];
  logic signed [HeW-1:0]   he_q [3], he_d [3];
  logic signed [RateW-1:0] rate_q [3], rate_d [3];
  logic signed [HincW-1:0] h_q [3], h_d [3];
  logic signed [TW-1:0]    t_q, t_d;
  logic signed [CW-1:0]    c_q [4], c_d [4];
  logic signed [ProdW-1:0] p_q, p_d;
  logic pneg_q, pneg_d, psh_q, psh_d;
  logic signed [AccuW-1:0] acc_q, acc_d;
  logic [63:0] sq_v_q, sq_v_d, sq_r_q, sq_r_d, sq_bit_q, sq_bit_d;
  logic [31:0] div_rem_q, div_rem_d, div_num_q, div_num_d;
  logic div_neg_q, div_neg_d;
  logic signed [QuatW-1:0] out_q [4], out_d [4];

  logic signed [MulW-1:0] op_a, op_b;
  logic op_neg, op_sh;
  logic [2:0] nterms;
  logic [5:0] rsh;
  logic signed [ProdW-1:0] prod;
  logic signed [AccuW-1:0] pterm, rnd;
  logic [64:0] sq_t;
  logic [32:0] div_r2;
  logic div_ge;
  logic [31:0] nval;
  logic signed [16:0] av17;
  logic [16:0] amag;
  logic [CW-1:0] cmag;
  logic [63:0] div_init;
  logic signed [AnW-1:0] quot;
  logic signed [33:0] isum;
  logic signed [31:0] isat;
  logic [CW-1:0] mc [4];
  logic [CW-1:0] mmax;
  logic [2:0] sft;
  logic signed [CW-1:0] cs [4];
  logic in_acc, accel_ok;

  function automatic logic signed [mau_pkg::AccuW-1:0] rshr(
      input logic signed [mau_pkg::AccuW-1:0] v, input logic [5:0] n);
    logic [mau_pkg::AccuW-1:0] mag;
    logic [mau_pkg::AccuW-1:0] r;
    mag = v[mau_pkg::AccuW-1] ? unsigned'(-v) : unsigned'(v);
    r = (mag + ((mau_pkg::AccuW)'(1) << (n - 6'd1))) >> n;
    return v[mau_pkg::AccuW-1] ? -signed'(r) : signed'(r);
  endfunction

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_neg = 1'b0;
    op_sh  = 1'b0;
    nterms = 3'd1;
    rsh    = 6'd30;
    case (job_q)
      mau_pkg::J_SS: begin
        nterms = 3'd3;
        op_a = MulW'(a_q[tm_q[1:0]]);
        op_b = MulW'(a_q[tm_q[1:0]]);
      end
      mau_pkg::J_HV0: begin
        nterms = 3'd2;
        if (tm_q == 3'd0) begin
          op_a = MulW'(quat_q[1]); op_b = MulW'(quat_q[3]);
        end else begin
          op_a = MulW'(quat_q[0]); op_b = MulW'(quat_q[2]); op_neg = 1'b1;
        end
      end
      mau_pkg::J_HV1: begin
        nterms = 3'd2;
        if (tm_q == 3'd0) begin
          op_a = MulW'(quat_q[0]); op_b = MulW'(quat_q[1]);
        end else begin
          op_a = MulW'(quat_q[2]); op_b = MulW'(quat_q[3]);
        end
      end
      mau_pkg::J_HV2: begin
        nterms = 3'd2;
        if (tm_q == 3'd0) begin
          op_a = MulW'(quat_q[0]); op_b = MulW'(quat_q[0]);
        end else begin
          op_a = MulW'(quat_q[3]); op_b = MulW'(quat_q[3]);
        end
      end
      mau_pkg::J_HE0: begin
        nterms = 3'd2;
        if (tm_q == 3'd0) begin
          op_a = MulW'(an_q[1]); op_b = MulW'(hv_q[2]);
        end else begin
          op_a = MulW'(an_q[2]); op_b = MulW'(hv_q[1]); op_neg = 1'b1;
        end
      end
      mau_pkg::J_HE1: begin
        nterms = 3'd2;
        if (tm_q == 3'd0) begin
          op_a = MulW'(an_q[2]); op_b = MulW'(hv_q[0]);
        end else begin
          op_a = MulW'(an_q[0]); op_b = MulW'(hv_q[2]); op_neg = 1'b1;
        end
      end
      mau_pkg::J_HE2: begin
        nterms = 3'd2;
        if (tm_q == 3'd0) begin
          op_a = MulW'(an_q[0]); op_b = MulW'(hv_q[1]);
        end else begin
          op_a = MulW'(an_q[1]); op_b = MulW'(hv_q[0]); op_neg = 1'b1;
        end
      end
      mau_pkg::J_T: begin
        rsh  = 6'd20;
        op_a = MulW'(igain_q);
        op_b = MulW'(he_q[ax_q]);
      end
      mau_pkg::J_I: begin
        nterms = 3'd2;
        rsh    = 6'd34;
        op_b   = MulW'(dt_q);
        if (tm_q == 3'd0) begin
          op_a = MulW'(t_q >>> 17); op_sh = 1'b1;
        end else begin
          op_a = MulW'({1'b0, t_q[16:0]});
        end
      end
      mau_pkg::J_P: begin
        rsh  = 6'd26;
        op_a = MulW'(prop_q);
        op_b = MulW'(he_q[ax_q]);
      end
      mau_pkg::J_H: begin
        nterms = 3'd2;
        rsh    = 6'd15;
        op_b   = MulW'(dt_q);
        if (tm_q == 3'd0) begin
          op_a = MulW'(rate_q[ax_q] >>> 17); op_sh = 1'b1;
        end else begin
          op_a = MulW'({1'b0, rate_q[ax_q][16:0]});
        end
      end
      mau_pkg::J_C0: begin
        nterms = 3'd3;
        op_neg = 1'b1;
        case (tm_q)
          3'd0:    begin op_a = MulW'(quat_q[1]); op_b = MulW'(h_q[0]); end
          3'd1:    begin op_a = MulW'(quat_q[2]); op_b = MulW'(h_q[1]); end
          default: begin op_a = MulW'(quat_q[3]); op_b = MulW'(h_q[2]); end
        endcase
      end
      mau_pkg::J_C1: begin
        nterms = 3'd3;
        case (tm_q)
          3'd0:    begin op_a = MulW'(quat_q[0]); op_b = MulW'(h_q[0]); end
          3'd1:    begin op_a = MulW'(quat_q[2]); op_b = MulW'(h_q[2]); end
          default: begin
            op_a = MulW'(quat_q[3]); op_b = MulW'(h_q[1]); op_neg = 1'b1;
          end
        endcase
      end
      mau_pkg::J_C2: begin
        nterms = 3'd3;
        case (tm_q)
          3'd0:    begin op_a = MulW'(quat_q[0]); op_b = MulW'(h_q[1]); end
          3'd1:    begin
            op_a = MulW'(quat_q[1]); op_b = MulW'(h_q[2]); op_neg = 1'b1;
          end
          default: begin op_a = MulW'(quat_q[3]); op_b = MulW'(h_q[0]); end
        endcase
      end
      mau_pkg::J_C3: begin
        nterms = 3'd3;
        case (tm_q)
          3'd0:    begin op_a = MulW'(quat_q[0]); op_b = MulW'(h_q[2]); end
          3'd1:    begin op_a = MulW'(quat_q[1]); op_b = MulW'(h_q[1]); end
          default: begin
            op_a = MulW'(quat_q[2]); op_b = MulW'(h_q[0]); op_neg = 1'b1;
          end
        endcase
      end
      mau_pkg::J_VV: begin
        nterms = 3'd4;
        op_a = MulW'(c_q[tm_q[1:0]]);
        op_b = MulW'(c_q[tm_q[1:0]]);
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  assign prod  = op_a * op_b;
  assign pterm = psh_q ? (AccuW'(p_q) <<< 17) : AccuW'(p_q);
  assign rnd   = rshr(acc_q, rsh);

  assign sq_t   = {1'b0, sq_r_q} + {1'b0, sq_bit_q};
  assign nval   = sq_r_q[31:0];
  assign div_r2 = {div_rem_q, div_num_q[31]};
  assign div_ge = div_r2 >= {1'b0, nval};

  assign av17 = 17'(a_q[dk_q]);
  assign amag = av17[16] ? unsigned'(-av17) : unsigned'(av17);
  assign cmag = c_q[dk_q][CW-1] ? unsigned'(-c_q[dk_q]) : unsigned'(c_q[dk_q]);
  assign div_init = (job_q == mau_pkg::J_SS) ?
                    ((64'(amag) << 46) + 64'(nval >> 1)) :
                    ((64'(cmag) << 30) + 64'(nval >> 1));
  assign quot = div_neg_q ? -signed'({1'b0, div_num_q}) : signed'({1'b0, div_num_q});

  assign isum = 34'(integ_q[ax_q]) + 34'(rnd);
  assign isat = (isum[33:31] != {3{isum[33]}}) ?
                (isum[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : isum[31:0];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mc[i] = c_q[i][CW-1] ? unsigned'(-c_q[i]) : unsigned'(c_q[i]);
    end
    mmax = mc[0];
    for (int i = 1; i < 4; i++) begin
      if (mc[i] > mmax) begin
        mmax = mc[i];
      end
    end
    sft = 3'd0;
    for (int j = 0; j < 5; j++) begin
      if ((mmax >> (31 + j)) != '0) begin
        sft = 3'(j + 1);
      end
    end
    for (int i = 0; i < 4; i++) begin
      cs[i] = c_q[i][CW-1] ? -signed'(mc[i] >> sft) : signed'(mc[i] >> sft);
    end
  end

  assign in_acc   = sample_i.valid && sample_i.ready;
  assign accel_ok = (sample_i.accel_x != '0) && (sample_i.accel_y != '0) &&
                    (sample_i.accel_z != '0);

  assign sample_i.ready = (state_q == mau_pkg::S_IDLE);
  assign cfg_i.ready    = 1'b1;
  assign result_o.valid  = out_valid_q;
  assign result_o.quat_w = out_q[0];
  assign result_o.quat_x = out_q[1];
  assign result_o.quat_y = out_q[2];
  assign result_o.quat_z = out_q[3];

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    tm_d        = tm_q;
    ax_d        = ax_q;
    dk_d        = dk_q;
    cnt_d       = cnt_q;
    prop_d      = prop_q;
    igain_d     = igain_q;
    quat_d      = quat_q;
    integ_d     = integ_q;
    out_valid_d = out_valid_q && !result_o.ready;
    a_d         = a_q;
    dt_d        = dt_q;
    an_d        = an_q;
    hv_d        = hv_q;
    he_d        = he_q;
    rate_d      = rate_q;
    h_d         = h_q;
    t_d         = t_q;
    c_d         = c_q;
    p_d         = p_q;
    pneg_d      = pneg_q;
    psh_d       = psh_q;
    acc_d       = acc_q;
    sq_v_d      = sq_v_q;
    sq_r_d      = sq_r_q;
    sq_bit_d    = sq_bit_q;
    div_rem_d   = div_rem_q;
    div_num_d   = div_num_q;
    div_neg_d   = div_neg_q;
    out_d       = out_q;

    if (cfg_i.valid) begin
      case (cfg_i.index)
        mau_pkg::RegPropGain:  prop_d  = cfg_i.data;
        mau_pkg::RegIntegGain: igain_d = cfg_i.data;
        default:               prop_d  = prop_q;
      endcase
    end

    case (state_q)
      mau_pkg::S_IDLE: begin
        if (in_acc) begin
          a_d[0]    = sample_i.accel_x;
          a_d[1]    = sample_i.accel_y;
          a_d[2]    = sample_i.accel_z;
          dt_d      = sample_i.time_step;
          rate_d[0] = RateW'(sample_i.gyro_x) <<< 4;
          rate_d[1] = RateW'(sample_i.gyro_y) <<< 4;
          rate_d[2] = RateW'(sample_i.gyro_z) <<< 4;
          tm_d      = 3'd0;
          ax_d      = 2'd0;
          job_d     = accel_ok ? mau_pkg::J_SS : mau_pkg::J_H;
          state_d   = mau_pkg::S_MAC;
        end
      end
      mau_pkg::S_MAC: begin
        if (tm_q < nterms) begin
          p_d    = prod;
          pneg_d = op_neg;
          psh_d  = op_sh;
        end
        if (tm_q == 3'd0) begin
          acc_d = (job_q == mau_pkg::J_HV2) ? -HalfQ60 : '0;
        end else begin
          acc_d = pneg_q ? acc_q - pterm : acc_q + pterm;
        end
        if (tm_q == nterms) begin
          state_d = mau_pkg::S_POST;
        end else begin
          tm_d = tm_q + 3'd1;
        end
      end
      mau_pkg::S_POST: begin
        tm_d    = 3'd0;
        state_d = mau_pkg::S_MAC;
        case (job_q)
          mau_pkg::J_SS, mau_pkg::J_VV: begin
            sq_v_d   = (job_q == mau_pkg::J_SS) ? {acc_q[31:0], 32'd0} : acc_q[63:0];
            sq_r_d   = '0;
            sq_bit_d = 64'h4000_0000_0000_0000;
            cnt_d    = '0;
            state_d  = mau_pkg::S_SQRT;
          end
          mau_pkg::J_HV0: begin hv_d[0] = HvW'(rnd); job_d = mau_pkg::J_HV1; end
          mau_pkg::J_HV1: begin hv_d[1] = HvW'(rnd); job_d = mau_pkg::J_HV2; end
          mau_pkg::J_HV2: begin hv_d[2] = HvW'(rnd); job_d = mau_pkg::J_HE0; end
          mau_pkg::J_HE0: begin he_d[0] = HeW'(rnd); job_d = mau_pkg::J_HE1; end
          mau_pkg::J_HE1: begin he_d[1] = HeW'(rnd); job_d = mau_pkg::J_HE2; end
          mau_pkg::J_HE2: begin
            he_d[2] = HeW'(rnd);
            ax_d    = 2'd0;
            if (igain_q == '0) begin
              integ_d = '{default: '0};
              job_d   = mau_pkg::J_P;
            end else begin
              job_d = mau_pkg::J_T;
            end
          end
          mau_pkg::J_T: begin t_d = TW'(rnd); job_d = mau_pkg::J_I; end
          mau_pkg::J_I: begin
            integ_d[ax_q] = isat;
            rate_d[ax_q]  = rate_q[ax_q] + (RateW'(isat) <<< 4);
            job_d         = mau_pkg::J_P;
          end
          mau_pkg::J_P: begin
            rate_d[ax_q] = rate_q[ax_q] + RateW'(rnd);
            if (ax_q == 2'd2) begin
              ax_d  = 2'd0;
              job_d = mau_pkg::J_H;
            end else begin
              ax_d  = ax_q + 2'd1;
              job_d = (igain_q == '0) ? mau_pkg::J_P : mau_pkg::J_T;
            end
          end
          mau_pkg::J_H: begin
            if (rnd > IncLim) begin
              h_d[ax_q] = HincW'(IncLim);
            end else if (rnd < -IncLim) begin
              h_d[ax_q] = HincW'(-IncLim);
            end else begin
              h_d[ax_q] = HincW'(rnd);
            end
            if (ax_q == 2'd2) begin
              ax_d  = 2'd0;
              job_d = mau_pkg::J_C0;
            end else begin
              ax_d = ax_q + 2'd1;
            end
          end
          mau_pkg::J_C0: begin
            c_d[0] = CW'(quat_q[0]) + CW'(rnd); job_d = mau_pkg::J_C1;
          end
          mau_pkg::J_C1: begin
            c_d[1] = CW'(quat_q[1]) + CW'(rnd); job_d = mau_pkg::J_C2;
          end
          mau_pkg::J_C2: begin
            c_d[2] = CW'(quat_q[2]) + CW'(rnd); job_d = mau_pkg::J_C3;
          end
          mau_pkg::J_C3: begin
            c_d[3]  = CW'(quat_q[3]) + CW'(rnd);
            state_d = mau_pkg::S_NORM;
          end
          default: begin
            state_d = mau_pkg::S_IDLE;
          end
        endcase
      end
      mau_pkg::S_SQRT: begin
        if ({1'b0, sq_v_q} >= sq_t) begin
          sq_v_d = sq_v_q - sq_t[63:0];
          sq_r_d = (sq_r_q >> 1) + sq_bit_q;
        end else begin
          sq_r_d = sq_r_q >> 1;
        end
        sq_bit_d = sq_bit_q >> 2;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = mau_pkg::S_SQDONE;
        end
      end
      mau_pkg::S_SQDONE: begin
        dk_d = 2'd0;
        if (job_q != mau_pkg::J_SS && nval == '0) begin
          quat_d  = '{OneQ30, '0, '0, '0};
          state_d = mau_pkg::S_OUT;
        end else begin
          state_d = mau_pkg::S_DINIT;
        end
      end
      mau_pkg::S_DINIT: begin
        div_rem_d = div_init[63:32];
        div_num_d = div_init[31:0];
        div_neg_d = (job_q == mau_pkg::J_SS) ? av17[16] : c_q[dk_q][CW-1];
        cnt_d     = '0;
        state_d   = mau_pkg::S_DIV;
      end
      mau_pkg::S_DIV: begin
        div_rem_d = div_ge ? 32'(div_r2 - {1'b0, nval}) : div_r2[31:0];
        div_num_d = {div_num_q[30:0], div_ge};
        cnt_d     = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = mau_pkg::S_DPOST;
        end
      end
      mau_pkg::S_DPOST: begin
        if (job_q == mau_pkg::J_SS) begin
          an_d[dk_q] = quot;
          if (dk_q == 2'd2) begin
            job_d   = mau_pkg::J_HV0;
            tm_d    = 3'd0;
            state_d = mau_pkg::S_MAC;
          end else begin
            dk_d    = dk_q + 2'd1;
            state_d = mau_pkg::S_DINIT;
          end
        end else begin
          if (quot > OneQ30s) begin
            quat_d[dk_q] = OneQ30;
          end else if (quot < -OneQ30s) begin
            quat_d[dk_q] = -OneQ30;
          end else begin
            quat_d[dk_q] = QuatW'(quot);
          end
          if (dk_q == 2'd3) begin
            state_d = mau_pkg::S_OUT;
          end else begin
            dk_d    = dk_q + 2'd1;
            state_d = mau_pkg::S_DINIT;
          end
        end
      end
      mau_pkg::S_NORM: begin
        c_d     = cs;
        job_d   = mau_pkg::J_VV;
        tm_d    = 3'd0;
        state_d = mau_pkg::S_MAC;
      end
      mau_pkg::S_OUT: begin
        if (!out_valid_q || result_o.ready) begin
          out_d       = quat_q;
          out_valid_d = 1'b1;
          state_d     = mau_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mau_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mau_pkg::S_IDLE;
      job_q       <= mau_pkg::J_SS;
      tm_q        <= '0;
      ax_q        <= '0;
      dk_q        <= '0;
      cnt_q       <= '0;
      prop_q      <= mau_pkg::PropGainRst;
      igain_q     <= mau_pkg::IntegGainRst;
      quat_q      <= '{OneQ30, '0, '0, '0};
      integ_q     <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      job_q       <= job_d;
      tm_q        <= tm_d;
      ax_q        <= ax_d;
      dk_q        <= dk_d;
      cnt_q       <= cnt_d;
      prop_q      <= prop_d;
      igain_q     <= igain_d;
      quat_q      <= quat_d;
      integ_q     <= integ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    dt_q      <= dt_d;
    an_q      <= an_d;
    hv_q      <= hv_d;
    he_q      <= he_d;
    rate_q    <= rate_d;
    h_q       <= h_d;
    t_q       <= t_d;
    c_q       <= c_d;
    p_q       <= p_d;
    pneg_q    <= pneg_d;
    psh_q     <= psh_d;
    acc_q     <= acc_d;
    sq_v_q    <= sq_v_d;
    sq_r_q    <= sq_r_d;
    sq_bit_q  <= sq_bit_d;
    div_rem_q <= div_rem_d;
    div_num_q <= div_num_d;
    div_neg_q <= div_neg_d;
    out_q     <= out_d;
  end

endmodule
`default_nettype wire
